/* hdl/ssp_pkg.sv */
// Shared types and constants for the seek-steering point mass.
// No dependencies.
`timescale 1ns / 1ps
package ssp_pkg;
  localparam logic [1:0] OP_SEEK   = 2'd0;
  localparam logic [1:0] OP_FORCE  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
  localparam logic [2:0] CFG_MAX_FORCE = 3'd1;
  localparam logic [2:0] CFG_START_X   = 3'd2;
  localparam logic [2:0] CFG_START_Y   = 3'd3;
  localparam logic [2:0] CFG_START_Z   = 3'd4;

  localparam logic [30:0] MAX_SPEED_RST = 31'd327680;
  localparam logic [30:0] MAX_FORCE_RST = 31'd6554;
  localparam int VEL_INIT = 196608;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SQ, ST_SQRT, ST_MUL, ST_DIV, ST_STEER, ST_UPDATE, ST_OUT
  } state_t;
endpackage

/* hdl/seek_steering_point_mass.sv */
// Top level of the seek-steering point mass: state, sequencer and shared
// iterative units. Depends on ssp_pkg.
`timescale 1ns / 1ps
// A 3D point mass with seek, apply-force and update requests. One request is
// in work at a time; in_stall is high from acceptance until the result has
// been taken, and the next request can be taken on the edge after that.
// Apply-force and unused opcodes pass through the steer state, and update
// through the update state, before the result is shown. A seek forms the
// differences, then three squares on one shared multiplier, a 32-step square
// root (two radicand bits per step), then per axis one multiply and a
// 64-step restoring division on the one shared divider, and then adds the
// steer. A target on the position skips to the steer after the first square.
// A shown result is held while out_stall is high.
module seek_steering_point_mass #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic signed [31:0] in_vec_x,
  input  logic signed [31:0] in_vec_y,
  input  logic signed [31:0] in_vec_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_speed_x,
  output logic signed [31:0] out_speed_y,
  output logic signed [31:0] out_speed_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
  localparam logic signed [33:0] CMAX = 34'sd2 ** (CW - 1) - 34'sd1;
  localparam logic signed [33:0] CMIN = -CMAX - 34'sd1;

  ssp_pkg::state_t state_r, state_nxt;

  logic [30:0] max_speed_r, max_force_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic signed [31:0] frc_r [3];
  logic signed [31:0] vec_r [3];
  logic [1:0]  op_r;
  logic signed [32:0] d_r [3];
  logic [32:0] mag_r [3];
  logic [1:0]  ax_r;
  logic [63:0] sum_r;
  logic [63:0] rem_r;       // sqrt radicand remainder
  logic [31:0] root_r;
  logic [5:0]  cnt_r;
  logic [63:0] prod_r;      // multiplier result / division dividend
  logic [63:0] quo_r;
  logic [64:0] drem_r;
  logic signed [33:0] des_r [3];

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
    return t[31:0];
  endfunction

  function automatic logic signed [33:0] clmp(input logic signed [33:0] v,
                                              input logic [30:0] lim);
    logic signed [33:0] l;
    l = $signed({3'b000, lim});
    return (v > l) ? l : ((v < -l) ? -l : v);
  endfunction

  // shift that brings all magnitudes below 2^31
  logic [1:0] shamt;
  always_comb begin
    shamt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (mag_r[i][32]) shamt = 2'd2;
      else if (mag_r[i][31] && shamt == 2'd0) shamt = 2'd1;
    end
  end
  logic [31:0] sh_mag;
  logic [32:0] sh_tmp;
  always_comb begin
    sh_tmp = mag_r[ax_r] >> shamt;
    sh_mag = sh_tmp[31:0];
  end

  // shared multiplier: square or times max_speed
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  assign mul_b = (state_r == ssp_pkg::ST_SQ) ? sh_mag : {1'b0, max_speed_r};
  assign mul_p = sh_mag * mul_b;

  // sqrt step
  logic [63:0] sq_trial, sq_rem2;
  logic [31:0] sq_root2;
  always_comb begin
    sq_trial = {rem_r[61:0], sum_r[63:62]};
    if (sq_trial >= {30'd0, root_r, 2'b01}) begin
      sq_rem2  = sq_trial - {30'd0, root_r, 2'b01};
      sq_root2 = {root_r[30:0], 1'b1};
    end else begin
      sq_rem2  = sq_trial;
      sq_root2 = {root_r[30:0], 1'b0};
    end
  end

  // restoring division step
  logic [64:0] dv_trial;
  always_comb dv_trial = {drem_r[63:0], prod_r[63]};

  logic all_zero;
  assign all_zero = (mag_r[0] == 33'd0) && (mag_r[1] == 33'd0) && (mag_r[2] == 33'd0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssp_pkg::ST_IDLE: if (in_valid) begin
        unique case (in_opcode)
          ssp_pkg::OP_SEEK:   state_nxt = ssp_pkg::ST_DIFF;
          ssp_pkg::OP_UPDATE: state_nxt = ssp_pkg::ST_UPDATE;
          default:            state_nxt = ssp_pkg::ST_STEER;
        endcase
      end
      ssp_pkg::ST_DIFF:   state_nxt = ssp_pkg::ST_SQ;
      ssp_pkg::ST_SQ:     if (all_zero) state_nxt = ssp_pkg::ST_STEER;
                          else if (ax_r == 2'd2) state_nxt = ssp_pkg::ST_SQRT;
      ssp_pkg::ST_SQRT:   if (cnt_r == 6'd31) state_nxt = ssp_pkg::ST_MUL;
      ssp_pkg::ST_MUL:    state_nxt = ssp_pkg::ST_DIV;
      ssp_pkg::ST_DIV:    if (cnt_r == 6'd0) state_nxt =
                            (ax_r == 2'd2) ? ssp_pkg::ST_STEER : ssp_pkg::ST_MUL;
      ssp_pkg::ST_STEER:  state_nxt = ssp_pkg::ST_OUT;
      ssp_pkg::ST_UPDATE: state_nxt = ssp_pkg::ST_OUT;
      ssp_pkg::ST_OUT:    if (!out_stall) state_nxt = ssp_pkg::ST_IDLE;
      default:            state_nxt = ssp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ssp_pkg::ST_IDLE);
    out_valid = (state_r == ssp_pkg::ST_OUT);
  end

  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];
  assign out_speed_x = vel_r[0];
  assign out_speed_y = vel_r[1];
  assign out_speed_z = vel_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ssp_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= ssp_pkg::MAX_SPEED_RST;
      max_force_r <= ssp_pkg::MAX_FORCE_RST;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        frc_r[i] <= '0;
      end
      vel_r[0] <= sat34(34'(ssp_pkg::VEL_INIT));
      vel_r[1] <= sat34(-34'(ssp_pkg::VEL_INIT));
      vel_r[2] <= sat34(34'(ssp_pkg::VEL_INIT));
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ssp_pkg::CFG_MAX_SPEED: max_speed_r <= cfg_data[30:0];
          ssp_pkg::CFG_MAX_FORCE: max_force_r <= cfg_data[30:0];
          ssp_pkg::CFG_START_X: pos_r[0] <= sat34(34'($signed(cfg_data)));
          ssp_pkg::CFG_START_Y: pos_r[1] <= sat34(34'($signed(cfg_data)));
          ssp_pkg::CFG_START_Z: pos_r[2] <= sat34(34'($signed(cfg_data)));
          default: ;
        endcase
      end
      if (state_r == ssp_pkg::ST_STEER) begin
        for (int i = 0; i < 3; i++) begin
          if (op_r == ssp_pkg::OP_SEEK)
            frc_r[i] <= sat34(34'(frc_r[i]) +
                        clmp(des_r[i] - 34'(vel_r[i]), max_force_r));
          else if (op_r == ssp_pkg::OP_FORCE)
            frc_r[i] <= sat34(34'(frc_r[i]) + 34'(vec_r[i]));
        end
      end
      if (state_r == ssp_pkg::ST_UPDATE) begin
        for (int i = 0; i < 3; i++) begin
          logic signed [31:0] nv;
          nv = sat34(clmp(34'(vel_r[i]) + 34'(frc_r[i]), max_speed_r));
          vel_r[i] <= nv;
          pos_r[i] <= sat34(34'(pos_r[i]) + 34'(nv));
          frc_r[i] <= '0;
        end
      end
    end
  end

  // datapath of the seek sequence
  always_ff @(posedge clk) begin
    unique case (state_r)
      ssp_pkg::ST_IDLE: begin
        op_r <= in_opcode;
        vec_r[0] <= in_vec_x;
        vec_r[1] <= in_vec_y;
        vec_r[2] <= in_vec_z;
        ax_r <= 2'd0;
        sum_r <= '0;
        for (int i = 0; i < 3; i++) des_r[i] <= '0;
      end
      ssp_pkg::ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [32:0] dd;
          dd = 33'(vec_r[i]) - 33'(pos_r[i]);
          d_r[i] <= dd;
          mag_r[i] <= dd[32] ? 33'(-dd) : 33'(dd);
        end
      end
      ssp_pkg::ST_SQ: begin
        sum_r <= sum_r + mul_p;
        ax_r <= ax_r + 2'd1;
        cnt_r <= '0;
        rem_r <= '0;
        root_r <= '0;
      end
      ssp_pkg::ST_SQRT: begin
        rem_r <= sq_rem2;
        root_r <= sq_root2;
        sum_r <= {sum_r[61:0], 2'b00};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) ax_r <= 2'd0;
      end
      ssp_pkg::ST_MUL: begin
        prod_r <= mul_p + {33'd0, root_r[31:1]};
        drem_r <= '0;
        quo_r <= '0;
        cnt_r <= 6'd63;
      end
      ssp_pkg::ST_DIV: begin
        if (dv_trial >= {33'd0, root_r}) begin
          drem_r <= dv_trial - {33'd0, root_r};
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          drem_r <= dv_trial;
          quo_r <= {quo_r[62:0], 1'b0};
        end
        prod_r <= {prod_r[62:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          logic [33:0] q;
          q = {quo_r[32:0], (dv_trial >= {33'd0, root_r})};
          des_r[ax_r] <= d_r[ax_r][32] ? -$signed(q) : $signed(q);
          ax_r <= ax_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_speed_x))
    else $error("stalled result changed");
  a_upd_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ssp_pkg::ST_UPDATE |=> frc_r[0] == 32'sd0 && frc_r[2] == 32'sd0)
    else $error("force not cleared by update");
`endif
endmodule

/* tb/seek_steering_point_mass_tb.sv */
// Testbench for seek_steering_point_mass: a behavioural model of the point mass
// predicts each result, and a monitor checks them against it. Depends on ssp_pkg.
`timescale 1ns / 1ps
module seek_steering_point_mass_tb;

  localparam int CW = 32;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } request_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } snapshot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic signed [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_speed_x, out_speed_y, out_speed_z;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  seek_steering_point_mass dut (.*);

  // Model state of the point mass and its registers
  longint model_speed_lim, model_force_lim;
  longint model_pos[3], model_vel[3], model_force[3];

  request_t  pending_requests[$];
  snapshot_t expected_states[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit failed = 1'b0;
  bit in_taken = 1'b0;
  int unsigned cycles = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > x) bit_w >>= 2;
    while (bit_w != 0) begin
      if (x >= res + bit_w) begin
        x -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return res;
  endfunction

  task automatic model_reset();
    model_speed_lim = longint'(ssp_pkg::MAX_SPEED_RST);
    model_force_lim = longint'(ssp_pkg::MAX_FORCE_RST);
    for (int i = 0; i < 3; i++) begin
      model_pos[i] = 0;
      model_force[i] = 0;
    end
    model_vel[0] = longint'(ssp_pkg::VEL_INIT);
    model_vel[1] = -longint'(ssp_pkg::VEL_INIT);
    model_vel[2] = longint'(ssp_pkg::VEL_INIT);
  endtask

  // Steer toward a target: desired velocity at max speed, minus the present one, clamped and added to the force
  function automatic void model_seek(longint tgt[3]);
    longint diff[3], want[3];
    longint unsigned mag[3], sumsq, norm, a, q;
    int sh;
    bit moving;
    sh = 0;
    moving = 1'b0;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      diff[i] = tgt[i] - model_pos[i];
      mag[i] = diff[i] < 0 ? -diff[i] : diff[i];
      if (mag[i] != 0) moving = 1'b1;
      want[i] = 0;
    end
    if (moving) begin
      for (int i = 0; i < 3; i++)
        while ((mag[i] >> sh) >= (64'd1 << 31)) sh++;
      for (int i = 0; i < 3; i++) begin
        a = mag[i] >> sh;
        sumsq += a * a;
      end
      norm = int_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        a = mag[i] >> sh;
        q = norm != 0 ? (a * longint'(model_speed_lim) + norm / 2) / norm : 0;
        want[i] = diff[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
    for (int i = 0; i < 3; i++)
      model_force[i] = clip(model_force[i] + clip(want[i] - model_vel[i],
                            -model_force_lim, model_force_lim), CMIN, CMAX);
  endfunction

  function automatic snapshot_t model_step(request_t r);
    longint v[3];
    snapshot_t s;
    v[0] = longint'(r.x);
    v[1] = longint'(r.y);
    v[2] = longint'(r.z);
    case (r.op)
      ssp_pkg::OP_SEEK: model_seek(v);
      ssp_pkg::OP_FORCE:
        for (int i = 0; i < 3; i++)
          model_force[i] = clip(model_force[i] + v[i], CMIN, CMAX);
      ssp_pkg::OP_UPDATE:
        for (int i = 0; i < 3; i++) begin
          model_vel[i] = clip(clip(model_vel[i] + model_force[i], -model_speed_lim,
                                   model_speed_lim), CMIN, CMAX);
          model_pos[i] = clip(model_pos[i] + model_vel[i], CMIN, CMAX);
          model_force[i] = 0;
        end
      default: ;
    endcase
    s.px = 32'(model_pos[0]);
    s.py = 32'(model_pos[1]);
    s.pz = 32'(model_pos[2]);
    s.vx = 32'(model_vel[0]);
    s.vy = 32'(model_vel[1]);
    s.vz = 32'(model_vel[2]);
    return s;
  endfunction

  // Predict each request at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_states = {expected_states, model_step(pending_requests.pop_front())};
      in_taken = 1'b1;
    end
  end

  // Driver: present the head of the queue once the previous request is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if ((!in_valid || in_taken) && pending_requests.size() != 0
          && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_opcode <= pending_requests[0].op;
        in_vec_x <= pending_requests[0].x;
        in_vec_y <= pending_requests[0].y;
        in_vec_z <= pending_requests[0].z;
      end else if (!in_valid || in_taken) begin
        in_valid <= 1'b0;
      end
      in_taken = 1'b0;
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  // Monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    snapshot_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_states.size() == 0) begin
        $error("result with no request outstanding");
        failed <= 1'b1;
      end else begin
        e = expected_states.pop_front();
        if (out_pos_x !== e.px) begin
          $error("pos_x expected %0d got %0d", e.px, out_pos_x); failed <= 1'b1;
        end
        if (out_pos_y !== e.py) begin
          $error("pos_y expected %0d got %0d", e.py, out_pos_y); failed <= 1'b1;
        end
        if (out_pos_z !== e.pz) begin
          $error("pos_z expected %0d got %0d", e.pz, out_pos_z); failed <= 1'b1;
        end
        if (out_speed_x !== e.vx) begin
          $error("speed_x expected %0d got %0d", e.vx, out_speed_x); failed <= 1'b1;
        end
        if (out_speed_y !== e.vy) begin
          $error("speed_y expected %0d got %0d", e.vy, out_speed_y); failed <= 1'b1;
        end
        if (out_speed_z !== e.vz) begin
          $error("speed_z expected %0d got %0d", e.vz, out_speed_z); failed <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'(int'($urandom_range(65535)) - 32768);
      3: return 32'(int'($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_request(logic [1:0] op, logic signed [31:0] x,
                               logic signed [31:0] y, logic signed [31:0] z);
    request_t r;
    r.op = op;
    r.x = x;
    r.y = y;
    r.z = z;
    pending_requests = {pending_requests, r};
  endtask

  // Hold until everything queued has been taken and checked
  task automatic drain();
    while (pending_requests.size() != 0 || expected_states.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Registers are only written while the block is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ssp_pkg::CFG_MAX_SPEED: model_speed_lim = longint'(val[30:0]);
      ssp_pkg::CFG_MAX_FORCE: model_force_lim = longint'(val[30:0]);
      ssp_pkg::CFG_START_X:   model_pos[0] = longint'($signed(val));
      ssp_pkg::CFG_START_Y:   model_pos[1] = longint'($signed(val));
      ssp_pkg::CFG_START_Z:   model_pos[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  // Seeks (x near the position), forces and ticks; a few odd opcodes
  task automatic queue_random(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 40)
        queue_request(ssp_pkg::OP_SEEK,
                      32'(model_pos[0] + longint'($urandom_range(4000000)) - 2000000),
                      rand_word(), rand_word());
      else if (k < 60)
        queue_request(ssp_pkg::OP_FORCE, rand_word(), rand_word(), rand_word());
      else if (k < 95)
        queue_request(ssp_pkg::OP_UPDATE, rand_word(), rand_word(), rand_word());
      else queue_request(ssp_pkg::OP_NONE, rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every opcode, target on the position, field extremes
    queue_request(ssp_pkg::OP_SEEK, 0, 0, 0);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_SEEK, 32'sh00100000, 32'sh00200000, -32'sh00050000);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_FORCE, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    queue_request(ssp_pkg::OP_FORCE, 32'sh7FFFFFFF, 32'sh80000000, -1);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_NONE, -1, -1, -1);
    queue_request(ssp_pkg::OP_SEEK, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    queue_request(ssp_pkg::OP_SEEK, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    drain();

    // Extreme limits and start position, then position saturation
    write_reg(ssp_pkg::CFG_MAX_SPEED, 32'hFFFFFFFF);
    write_reg(ssp_pkg::CFG_MAX_FORCE, 32'hFFFFFFFF);
    write_reg(ssp_pkg::CFG_START_X, 32'h7FFFFFFF);
    write_reg(ssp_pkg::CFG_START_Y, 32'h80000000);
    write_reg(ssp_pkg::CFG_START_Z, 32'h0);
    queue_request(ssp_pkg::OP_SEEK, 32'sh80000000, 32'sh7FFFFFFF, 0);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_FORCE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    queue_request(ssp_pkg::OP_SEEK, 32'sh7FFFFFFF, 32'sh80000000, 0);
    drain();
    write_reg(ssp_pkg::CFG_MAX_SPEED, 32'h0);
    write_reg(ssp_pkg::CFG_MAX_FORCE, 32'h0);
    queue_request(ssp_pkg::OP_SEEK, 12345, 0, 0);
    queue_request(ssp_pkg::OP_FORCE, 100, -100, 5);
    queue_request(ssp_pkg::OP_UPDATE, 0, 0, 0);
    drain();

    // Random phases across settings and idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ssp_pkg::CFG_MAX_SPEED,
                ph == 5 ? 32'h7FFFFFFF : $urandom_range(2000000));
      write_reg(ssp_pkg::CFG_MAX_FORCE,
                ph == 4 ? 32'h7FFFFFFF : $urandom_range(200000));
      write_reg(ssp_pkg::CFG_START_X, rand_word());
      write_reg(ssp_pkg::CFG_START_Y, $urandom_range(2000000) - 1000000);
      write_reg(ssp_pkg::CFG_START_Z, $urandom);
      send_idle_pct = ph < 2 ? 36 : (ph < 4 ? 49 : 0);
      recv_idle_pct = ph < 2 ? 49 : (ph < 4 ? 36 : 0);
      queue_random(150);
      // Hold off queueing until the block has caught up, then carry on
      while (expected_states.size() != 0 || pending_requests.size() > 75)
        @(posedge clk);
      queue_random(150);
      drain();
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

/* files.f */
hdl/ssp_pkg.sv
hdl/seek_steering_point_mass.sv
tb/seek_steering_point_mass_tb.sv
